// ===== src/qdt_pkg.sv =====
`default_nettype none

package qdt_pkg;

	typedef struct packed {
		logic [1:0] encoder_pins;
		logic       enabled;
		logic [1:0] mode;
	} tick_word_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
		logic [1:0] direction;
		logic [4:0] blend_level;
	} frame_word_t;

	typedef enum logic [2:0] {
		CFG_CTRL_HIGH  = 3'd0,
		CFG_CTRL_LOW   = 3'd1,
		CFG_CHANNEL    = 3'd2,
		CFG_WORD_FOUR  = 3'd3,
		CFG_WORD_FIVE  = 3'd4,
		CFG_WORD_SIX   = 3'd5,
		CFG_WORD_SEVEN = 3'd6
	} cfg_index_t;

	localparam logic [1:0] MODE_SEEK  = 2'd0;
	localparam logic [1:0] MODE_BLEND = 2'd1;

	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_CCW  = 2'd1;
	localparam logic [1:0] DIR_CW   = 2'd2;

	localparam logic [7:0] HIST_CW       = 8'd203;
	localparam logic [7:0] HIST_CCW      = 8'd227;
	localparam logic [7:0] HIST_RESTART  = 8'h03;
	localparam logic [7:0] BUS_ADDR      = 8'h20;
	localparam logic [7:0] SEEK_UP       = 8'b1100_0011;
	localparam logic [7:0] SEEK_DOWN     = 8'b1100_0001;
	localparam logic [4:0] BLEND_MAX     = 5'd31;
	localparam logic [4:0] BLEND_RESET   = 5'd26;
	localparam logic [3:0] LAST_IDX      = 4'd12;

	localparam logic [7:0]  CTRL_HIGH_RESET  = 8'd194;
	localparam logic [7:0]  CTRL_LOW_RESET   = 8'd1;
	localparam logic [15:0] CHANNEL_RESET    = 16'd0;
	localparam logic [15:0] WORD_FOUR_RESET  = 16'd0;
	localparam logic [15:0] WORD_FIVE_RESET  = 16'd34959;
	localparam logic [15:0] WORD_SIX_RESET   = 16'd0;
	localparam logic [7:0]  WORD_SEVEN_RESET = 8'd2;

endpackage

`default_nettype wire

// ===== src/quadrature_detent_tuner_frame.sv =====
// A detent's accepted tick sets the busy flag; the first frame byte then loads into the output register.
// Throughput: with no frame in flight, a tick without a frame is taken every cycle; a tick that starts
// a frame stalls the tick channel until all 13 frame bytes are loaded into the output register.
// Reset: history clears to zero, blend level to 26, registers to their defaults;
// no frame is pending and the output register is empty.
`default_nettype none

module quadrature_detent_tuner_frame
	import qdt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        tick_valid,
	output logic             tick_stall,
	input  wire tick_word_t  tick,
	output logic             frame_valid,
	input  wire logic        frame_stall,
	output frame_word_t      frame
);

	logic [7:0]  ctrl_high_q;
	logic [7:0]  ctrl_low_q;
	logic [15:0] channel_q;
	logic [15:0] word_four_q;
	logic [15:0] word_five_q;
	logic [15:0] word_six_q;
	logic [7:0]  word_seven_q;

	logic [7:0]  history_q;
	logic [4:0]  blend_count_q;
	logic        busy_q;
	logic [3:0]  idx_q;
	logic [1:0]  dir_q;
	logic [7:0]  cmd_q;
	logic        out_valid_q;
	frame_word_t out_q;

	logic        tick_take;
	logic [7:0]  history_shift;
	logic [1:0]  dir_d;
	logic        frame_start;
	logic [4:0]  blend_next;
	logic        out_load;
	logic [7:0]  byte_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_high_q  <= CTRL_HIGH_RESET;
			ctrl_low_q   <= CTRL_LOW_RESET;
			channel_q    <= CHANNEL_RESET;
			word_four_q  <= WORD_FOUR_RESET;
			word_five_q  <= WORD_FIVE_RESET;
			word_six_q   <= WORD_SIX_RESET;
			word_seven_q <= WORD_SEVEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CTRL_HIGH:  ctrl_high_q  <= cfg_data[7:0];
				CFG_CTRL_LOW:   ctrl_low_q   <= cfg_data[7:0];
				CFG_CHANNEL:    channel_q    <= cfg_data;
				CFG_WORD_FOUR:  word_four_q  <= cfg_data;
				CFG_WORD_FIVE:  word_five_q  <= cfg_data;
				CFG_WORD_SIX:   word_six_q   <= cfg_data;
				CFG_WORD_SEVEN: word_seven_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	assign tick_stall = busy_q;
	assign tick_take  = tick_valid && !busy_q && tick.enabled;

	always_comb begin
		history_shift = history_q;
		if (history_q[1:0] != tick.encoder_pins) begin
			history_shift = {history_q[5:0], tick.encoder_pins};
		end
		priority if (history_shift == HIST_CW) begin
			dir_d = DIR_CW;
		end else if (history_shift == HIST_CCW) begin
			dir_d = DIR_CCW;
		end else begin
			dir_d = DIR_NONE;
		end
	end

	assign frame_start = (dir_d != DIR_NONE) &&
		((tick.mode == MODE_SEEK) || (tick.mode == MODE_BLEND));

	always_comb begin
		if (dir_d == DIR_CW) begin
			blend_next = (blend_count_q == BLEND_MAX) ? 5'd0 : blend_count_q + 5'd1;
		end else begin
			blend_next = (blend_count_q == 5'd0) ? BLEND_MAX : blend_count_q - 5'd1;
		end
	end

	assign out_load = busy_q && (!out_valid_q || !frame_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			history_q     <= '0;
			blend_count_q <= BLEND_RESET;
			busy_q        <= 1'b0;
			idx_q         <= '0;
		end else begin
			if (tick_take) begin
				history_q <= (dir_d != DIR_NONE) ? HIST_RESTART : history_shift;
				if (frame_start) begin
					busy_q <= 1'b1;
					idx_q  <= '0;
				end
				if (frame_start && tick.mode == MODE_BLEND) begin
					blend_count_q <= blend_next;
				end
			end else if (out_load) begin
				idx_q <= idx_q + 4'd1;
				if (idx_q == LAST_IDX) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_take && frame_start) begin
			dir_q <= dir_d;
			if (tick.mode == MODE_SEEK) begin
				cmd_q <= (dir_d == DIR_CW) ? SEEK_UP : SEEK_DOWN;
			end else begin
				cmd_q <= ctrl_high_q;
			end
		end
	end

	always_comb begin
		unique case (idx_q)
			4'd0:    byte_sel = BUS_ADDR;
			4'd1:    byte_sel = cmd_q;
			4'd2:    byte_sel = ctrl_low_q;
			4'd3:    byte_sel = channel_q[15:8];
			4'd4:    byte_sel = channel_q[7:0];
			4'd5:    byte_sel = word_four_q[15:8];
			4'd6:    byte_sel = word_four_q[7:0];
			4'd7:    byte_sel = word_five_q[15:8];
			4'd8:    byte_sel = word_five_q[7:0];
			4'd9:    byte_sel = word_six_q[15:8];
			4'd10:   byte_sel = word_six_q[7:0];
			4'd11:   byte_sel = {blend_count_q, 3'b000} >> 1;
			4'd12:   byte_sel = word_seven_q;
			default: byte_sel = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!frame_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.frame_byte  <= byte_sel;
			out_q.last_byte   <= (idx_q == LAST_IDX);
			out_q.direction   <= dir_q;
			out_q.blend_level <= blend_count_q;
		end
	end

	assign frame_valid = out_valid_q;
	assign frame       = out_q;

`ifndef SYNTHESIS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q <= LAST_IDX))
		else $error("frame byte counter ran past the last byte");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_take && frame_start) |=> busy_q)
		else $error("detent did not start a frame");

	a_frame_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_valid && !frame.last_byte && !frame_stall) |=> frame_valid)
		else $error("frame word missing after a taken inner word");

	a_blend_hold: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> $stable(blend_count_q))
		else $error("blend level changed while a frame was in flight");
`endif

endmodule

`default_nettype wire

// ===== bench/quadrature_detent_tuner_frame_test.sv =====
`timescale 1ns / 1ps

module quadrature_detent_tuner_frame_test;
	import qdt_pkg::*;

	localparam logic [1:0] MODE_IDLE  = 2'd2;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	localparam int SET_ONES   = 0;
	localparam int SET_ZEROS  = 1;
	localparam int SET_RANDOM = 2;

	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        tick_valid = 1'b0;
	logic        tick_stall;
	tick_word_t  tick = '0;
	logic        frame_valid;
	logic        frame_stall = 1'b0;
	frame_word_t frame;

	tick_word_t  pending_ticks[$];
	frame_word_t frame_bytes_due[$];

	int tick_gap_pct = 0;
	int frame_hold_pct = 0;
	int bad_words = 0;
	int cycle_count = 0;

	logic [7:0]  pin_trail = '0;
	logic [4:0]  blend_now = BLEND_RESET;
	logic [7:0]  reg_ctrl_high = CTRL_HIGH_RESET;
	logic [7:0]  reg_ctrl_low = CTRL_LOW_RESET;
	logic [15:0] reg_channel = CHANNEL_RESET;
	logic [15:0] reg_word_four = WORD_FOUR_RESET;
	logic [15:0] reg_word_five = WORD_FIVE_RESET;
	logic [15:0] reg_word_six = WORD_SIX_RESET;
	logic [7:0]  reg_word_seven = WORD_SEVEN_RESET;

	quadrature_detent_tuner_frame dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.tick_valid  (tick_valid),
		.tick_stall  (tick_stall),
		.tick        (tick),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.frame       (frame)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	task automatic predict_tick(input tick_word_t t);
		logic [1:0]  dir;
		logic [7:0]  cmd;
		logic [7:0]  bytes [13];
		frame_word_t w;
		dir = DIR_NONE;
		cmd = '0;
		if (!t.enabled)
			return;
		if (pin_trail[1:0] != t.encoder_pins)
			pin_trail = {pin_trail[5:0], t.encoder_pins};
		if (pin_trail == HIST_CW) begin
			dir = DIR_CW;
			pin_trail = HIST_RESTART;
		end else if (pin_trail == HIST_CCW) begin
			dir = DIR_CCW;
			pin_trail = HIST_RESTART;
		end
		if (dir == DIR_NONE)
			return;
		if (t.mode == MODE_SEEK) begin
			cmd = (dir == DIR_CW) ? SEEK_UP : SEEK_DOWN;
		end else if (t.mode == MODE_BLEND) begin
			if (dir == DIR_CW)
				blend_now = (blend_now == BLEND_MAX) ? 5'd0 : blend_now + 5'd1;
			else
				blend_now = (blend_now == 5'd0) ? BLEND_MAX : blend_now - 5'd1;
			cmd = reg_ctrl_high;
		end else begin
			return;
		end
		bytes = '{BUS_ADDR, cmd, reg_ctrl_low, reg_channel[15:8], reg_channel[7:0],
			reg_word_four[15:8], reg_word_four[7:0], reg_word_five[15:8],
			reg_word_five[7:0], reg_word_six[15:8], reg_word_six[7:0],
			{1'b0, blend_now, 2'b00}, reg_word_seven};
		for (int k = 0; k < 13; k++) begin
			w.frame_byte = bytes[k];
			w.last_byte = (k == int'(LAST_IDX));
			w.direction = dir;
			w.blend_level = blend_now;
			frame_bytes_due.push_back(w);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_valid <= 1'b0;
		end else if (!tick_valid || !tick_stall) begin
			if (tick_valid)
				predict_tick(tick);
			if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= tick_gap_pct) begin
				tick <= pending_ticks.pop_front();
				tick_valid <= 1'b1;
			end else begin
				tick_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_stall <= 1'b0;
		end else begin
			if (frame_valid && !frame_stall) begin
				if (frame_bytes_due.size() == 0) begin
					$error("unexpected frame word %0h", frame);
					bad_words++;
				end else begin
					frame_word_t want;
					want = frame_bytes_due.pop_front();
					if (frame.frame_byte !== want.frame_byte) begin
						$error("frame_byte expected %0h actual %0h", want.frame_byte,
							frame.frame_byte);
						bad_words++;
					end
					if (frame.last_byte !== want.last_byte) begin
						$error("last_byte expected %0h actual %0h", want.last_byte,
							frame.last_byte);
						bad_words++;
					end
					if (frame.direction !== want.direction) begin
						$error("direction expected %0h actual %0h", want.direction,
							frame.direction);
						bad_words++;
					end
					if (frame.blend_level !== want.blend_level) begin
						$error("blend_level expected %0h actual %0h", want.blend_level,
							frame.blend_level);
						bad_words++;
					end
				end
			end
			frame_stall <= ($urandom_range(0, 99) < frame_hold_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("quadrature_detent_tuner_frame: mismatch");
			$finish;
		end
	end

	function automatic int push_tick(input logic [1:0] pins, input logic en,
			input logic [1:0] mode);
		tick_word_t t;
		t.encoder_pins = pins;
		t.enabled = en;
		t.mode = mode;
		pending_ticks.push_back(t);
		return int'(en);
	endfunction

	// One detent gesture, with stray disabled ticks and pin repeats mixed in.
	function automatic int push_detent(input logic cw, input logic [1:0] final_mode);
		logic [1:0] path [4];
		int n;
		n = 0;
		if (cw)
			path = '{2'd3, 2'd0, 2'd2, 2'd3};
		else
			path = '{2'd3, 2'd2, 2'd0, 2'd3};
		for (int i = 0; i < 4; i++) begin
			if ($urandom_range(0, 99) < 15)
				void'(push_tick(2'($urandom), 1'b0, 2'($urandom)));
			n += push_tick(path[i], 1'b1, (i == 3) ? final_mode : 2'($urandom));
			if ($urandom_range(0, 99) < 15)
				n += push_tick(path[i], 1'b1, 2'($urandom));
		end
		return n;
	endfunction

	task automatic queue_random_ticks(input int target);
		int added;
		int r;
		logic cw;
		logic [1:0] pick_mode;
		added = 0;
		cw = 1'($urandom);
		while (added < target) begin
			if ($urandom_range(0, 99) < 75) begin
				if ($urandom_range(0, 99) < 20)
					cw = ~cw;
				r = $urandom_range(0, 9);
				if (r < 5)
					pick_mode = MODE_BLEND;
				else if (r < 8)
					pick_mode = MODE_SEEK;
				else
					pick_mode = (r == 8) ? MODE_IDLE : MODE_SPARE;
				added += push_detent(cw, pick_mode);
			end else begin
				repeat ($urandom_range(1, 3))
					added += push_tick(2'($urandom), 1'($urandom), 2'($urandom));
			end
		end
	endtask

	task automatic program_tuner(input int style);
		cfg_index_t idx;
		logic [15:0] val;
		idx = idx.first();
		repeat (idx.num()) begin
			if (style == SET_ONES)
				val = 16'hFFFF;
			else if (style == SET_ZEROS)
				val = 16'h0000;
			else
				val = 16'($urandom);
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_data <= val;
			case (idx)
				CFG_CTRL_HIGH:  reg_ctrl_high = val[7:0];
				CFG_CTRL_LOW:   reg_ctrl_low = val[7:0];
				CFG_CHANNEL:    reg_channel = val;
				CFG_WORD_FOUR:  reg_word_four = val;
				CFG_WORD_FIVE:  reg_word_five = val;
				CFG_WORD_SIX:   reg_word_six = val;
				CFG_WORD_SEVEN: reg_word_seven = val[7:0];
				default: ;
			endcase
			idx = idx.next();
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Sampled on the falling edge so that the driver and monitor updates have settled.
	task automatic wait_quiet();
		@(negedge clk);
		while (pending_ticks.size() != 0 || tick_valid || frame_bytes_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		void'(push_tick(2'd3, 1'b0, MODE_SEEK));
		void'(push_tick(2'd3, 1'b1, MODE_SEEK));
		void'(push_tick(2'd0, 1'b1, MODE_SEEK));
		void'(push_tick(2'd0, 1'b1, MODE_BLEND));
		void'(push_tick(2'd2, 1'b1, MODE_SEEK));
		void'(push_tick(2'd3, 1'b1, MODE_SEEK));
		void'(push_tick(2'd2, 1'b1, MODE_BLEND));
		void'(push_tick(2'd0, 1'b1, MODE_IDLE));
		void'(push_tick(2'd3, 1'b1, MODE_SEEK));
		void'(push_tick(2'd0, 1'b1, MODE_SEEK));
		void'(push_tick(2'd2, 1'b1, MODE_SEEK));
		void'(push_tick(2'd3, 1'b1, MODE_IDLE));
		void'(push_tick(2'd2, 1'b1, MODE_SEEK));
		void'(push_tick(2'd0, 1'b1, MODE_SEEK));
		void'(push_tick(2'd1, 1'b0, MODE_BLEND));
		void'(push_tick(2'd3, 1'b1, MODE_SPARE));
		repeat (2) begin
			void'(push_tick(2'd0, 1'b1, MODE_SEEK));
			void'(push_tick(2'd2, 1'b1, MODE_SEEK));
			void'(push_tick(2'd3, 1'b1, MODE_BLEND));
		end
		void'(push_tick(2'd2, 1'b1, MODE_SEEK));
		void'(push_tick(2'd0, 1'b1, MODE_SEEK));
		void'(push_tick(2'd3, 1'b1, MODE_BLEND));
		wait_quiet();

		program_tuner(SET_ONES);
		queue_random_ticks(52);
		wait_quiet();

		program_tuner(SET_ZEROS);
		tick_gap_pct = 57;
		queue_random_ticks(52);
		wait_quiet();

		program_tuner(SET_RANDOM);
		tick_gap_pct = 0;
		frame_hold_pct = 57;
		queue_random_ticks(52);
		wait_quiet();

		program_tuner(SET_RANDOM);
		tick_gap_pct = 20;
		frame_hold_pct = 20;
		queue_random_ticks(52);
		wait_quiet();

		if (bad_words == 0)
			$display("quadrature_detent_tuner_frame: match");
		else
			$display("quadrature_detent_tuner_frame: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
src/qdt_pkg.sv
src/quadrature_detent_tuner_frame.sv
bench/quadrature_detent_tuner_frame_test.sv
